// ----- hw/rtl/ppi_pkg.sv -----
// shared types and constants for the particle pool integrator
package ppi_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int SLOT_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam logic [16:0] DAMP_ONE = 17'd65536;
    localparam logic [23:0] AGE_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic               kind;
        logic [15:0]        dt;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic [23:0]        lifetime;
    } ppi_req_t;

    typedef struct packed {
        logic               result_kind;
        logic [5:0]         slot;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               point_valid;
        logic               pool_full;
        logic               last;
    } ppi_rsp_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic [23:0]        age;
        logic [23:0]        lifespan;
    } ppi_rec_t;

    // controls for the shared multiply / round / saturate unit
    typedef struct packed {
        logic               en;
        logic signed [15:0] op_a;
        logic [16:0]        op_b;
        logic signed [15:0] addend;
        logic               sh20;
    } ppi_alu_ctl_t;

    typedef enum logic [2:0] {
        OP_VX_ACC,
        OP_VY_ACC,
        OP_VX_DMP,
        OP_VY_DMP,
        OP_PX,
        OP_PY
    } ppi_op_t;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_SPAWN = 1'b1;

endpackage

// ----- hw/rtl/ppi_ram.sv -----
// generic single write port ram with registered read
module ppi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ppi_alu.sv -----
// shared multiply, round half up, add and saturate unit
module ppi_alu
    import ppi_pkg::*;
(
    input  logic               clk,
    input  ppi_alu_ctl_t       ctl,
    output logic signed [15:0] result
);

    logic signed [33:0] prod_reg;
    logic signed [15:0] addend_reg;
    logic               sh20_reg;
    logic signed [34:0] rnd;
    logic signed [34:0] shifted;
    logic signed [34:0] sum;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg   <= ctl.op_a * $signed({1'b0, ctl.op_b});
            addend_reg <= ctl.addend;
            sh20_reg   <= ctl.sh20;
        end
    end

    always_comb
    begin
        // arithmetic shift after adding half gives floor(x + 1/2)
        if (sh20_reg)
        begin
            rnd     = 35'(prod_reg) + 35'sd524288;
            shifted = rnd >>> 20;
        end
        else
        begin
            rnd     = 35'(prod_reg) + 35'sd32768;
            shifted = rnd >>> 16;
        end
        sum = shifted + 35'(addend_reg);
        if (sum > 35'sd32767)
        begin
            result = 16'sh7FFF;
        end
        else if (sum < -35'sd32768)
        begin
            result = -16'sh8000;
        end
        else
        begin
            result = sum[15:0];
        end
    end

endmodule

// ----- hw/rtl/particle_pool_integrator_top.sv -----
// particle pool integrator: sequencer, slot flags, damping register and datapath
//
//  channel   | signals                | direction | handshake
//  ----------+------------------------+-----------+-----------------------------
//  request   | start, req, busy       | in        | taken when start & !busy
//  result    | rsp_valid, rsp         | out       | one cycle strobe, no stall
//  damping   | damping_we, damping_wdata | in     | written when damping_we
//
// spawn: scans the slots in order for the lowest free slot, then answers
// with it or with pool_full. tick: skips dead slots, frees expiring ones,
// and takes each surviving slot through ram read, age check, six multiply
// ops on the one shared multiplier, and write back, then ends in S_T_END.
// reset empties the pool and sets damping to one; no clearing pass.
// results cannot be stalled; busy drops in the same cycle that the last result is valid.
module particle_pool_integrator_top
    import ppi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  ppi_req_t    req,
    output logic        busy,
    output logic        rsp_valid,
    output ppi_rsp_t    rsp,
    input  logic        damping_we,
    input  logic [16:0] damping_wdata
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SPAWN = 8'b0000_0010,
        S_T_RD  = 8'b0000_0100,
        S_T_AGE = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_ACC   = 8'b0010_0000,
        S_T_WB  = 8'b0100_0000,
        S_T_END = 8'b1000_0000
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_PARTICLES - 1);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    ppi_op_t             op_reg, op_next;
    logic [MAX_PARTICLES-1:0] alive_reg, alive_next;
    logic [16:0]         damping_reg;
    ppi_req_t            req_reg;
    ppi_rec_t            rec_reg, rec_next;
    ppi_rsp_t            pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    ppi_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                ram_we;
    logic                ram_re;
    ppi_rec_t            ram_wdata;
    ppi_rec_t            ram_rdata;
    ppi_alu_ctl_t        alu_ctl;
    logic signed [15:0]  alu_result;
    logic [24:0]         age_sum;
    logic [23:0]         age_sat;

    ppi_ram #(
        .WIDTH($bits(ppi_rec_t)),
        .DEPTH(MAX_PARTICLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    ppi_alu u_alu (
        .clk    (clk),
        .ctl    (alu_ctl),
        .result (alu_result)
    );

    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign age_sum = {1'b0, ram_rdata.age} + {9'd0, req_reg.dt};
    assign age_sat = age_sum[24] ? AGE_MAX : age_sum[23:0];

    always_comb
    begin
        alu_ctl.en     = (state_reg == S_MUL);
        alu_ctl.op_a   = rec_reg.acc_x;
        alu_ctl.op_b   = {1'b0, req_reg.dt};
        alu_ctl.addend = rec_reg.vel_x;
        alu_ctl.sh20   = 1'b0;
        unique case (op_reg)
            OP_VX_ACC:
            begin
                alu_ctl.op_a   = rec_reg.acc_x;
                alu_ctl.addend = rec_reg.vel_x;
            end
            OP_VY_ACC:
            begin
                alu_ctl.op_a   = rec_reg.acc_y;
                alu_ctl.addend = rec_reg.vel_y;
            end
            OP_VX_DMP:
            begin
                alu_ctl.op_a   = rec_reg.vel_x;
                alu_ctl.op_b   = damping_reg;
                alu_ctl.addend = '0;
            end
            OP_VY_DMP:
            begin
                alu_ctl.op_a   = rec_reg.vel_y;
                alu_ctl.op_b   = damping_reg;
                alu_ctl.addend = '0;
            end
            OP_PX:
            begin
                alu_ctl.op_a   = rec_reg.vel_x;
                alu_ctl.addend = rec_reg.pos_x;
                alu_ctl.sh20   = 1'b1;
            end
            OP_PY:
            begin
                alu_ctl.op_a   = rec_reg.vel_y;
                alu_ctl.addend = rec_reg.pos_y;
                alu_ctl.sh20   = 1'b1;
            end
            default:
            begin
                alu_ctl.op_a = rec_reg.acc_x;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        alive_next      = alive_reg;
        rec_next        = rec_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = rec_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next        = '0;
                pend_valid_next = 1'b0;
                if (start)
                begin
                    state_next = (req.kind == KIND_SPAWN) ? S_SPAWN : S_T_RD;
                end
            end
            S_SPAWN:
            begin
                rsp_next             = '0;
                rsp_next.result_kind = KIND_SPAWN;
                rsp_next.last        = 1'b1;
                if (!alive_reg[idx_reg])
                begin
                    ram_we                = 1'b1;
                    ram_wdata.pos_x       = req_reg.pos_x;
                    ram_wdata.pos_y       = req_reg.pos_y;
                    ram_wdata.vel_x       = req_reg.vel_x;
                    ram_wdata.vel_y       = req_reg.vel_y;
                    ram_wdata.acc_x       = req_reg.acc_x;
                    ram_wdata.acc_y       = req_reg.acc_y;
                    ram_wdata.age         = '0;
                    ram_wdata.lifespan    = req_reg.lifetime;
                    alive_next[idx_reg]   = 1'b1;
                    rsp_next.slot         = 6'(idx_reg);
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    rsp_next.pool_full = 1'b1;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_T_RD:
            begin
                if (alive_reg[idx_reg])
                begin
                    ram_re     = 1'b1;
                    state_next = S_T_AGE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_T_END;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_T_AGE:
            begin
                if (age_sat > ram_rdata.lifespan)
                begin
                    alive_next[idx_reg] = 1'b0;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_T_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_T_RD;
                    end
                end
                else
                begin
                    rec_next     = ram_rdata;
                    rec_next.age = age_sat;
                    op_next      = OP_VX_ACC;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_MUL;
                unique case (op_reg)
                    OP_VX_ACC:
                    begin
                        rec_next.vel_x = alu_result;
                        op_next        = OP_VY_ACC;
                    end
                    OP_VY_ACC:
                    begin
                        rec_next.vel_y = alu_result;
                        op_next        = OP_VX_DMP;
                    end
                    OP_VX_DMP:
                    begin
                        rec_next.vel_x = alu_result;
                        op_next        = OP_VY_DMP;
                    end
                    OP_VY_DMP:
                    begin
                        rec_next.vel_y = alu_result;
                        op_next        = OP_PX;
                    end
                    OP_PX:
                    begin
                        rec_next.pos_x = alu_result;
                        op_next        = OP_PY;
                    end
                    OP_PY:
                    begin
                        rec_next.pos_y = alu_result;
                        state_next     = S_T_WB;
                    end
                    default:
                    begin
                        state_next = S_T_WB;
                    end
                endcase
            end
            S_T_WB:
            begin
                ram_we = 1'b1;
                // the held point goes out once another survivor follows it
                if (pend_valid_reg)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                end
                pend_next             = '0;
                pend_next.result_kind = KIND_TICK;
                pend_next.slot        = 6'(idx_reg);
                pend_next.point_x     = rec_reg.pos_x;
                pend_next.point_y     = rec_reg.pos_y;
                pend_next.point_valid = 1'b1;
                pend_valid_next       = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_T_END;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_T_RD;
                end
            end
            S_T_END:
            begin
                if (pend_valid_reg)
                begin
                    rsp_next = pend_reg;
                end
                else
                begin
                    rsp_next             = '0;
                    rsp_next.result_kind = KIND_TICK;
                end
                rsp_next.last   = 1'b1;
                rsp_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            op_reg         <= OP_VX_ACC;
            alive_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            damping_reg    <= DAMP_ONE;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            op_reg         <= op_next;
            alive_reg      <= alive_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (damping_we)
            begin
                damping_reg <= (damping_wdata > DAMP_ONE) ? DAMP_ONE : damping_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= req;
        end
        rec_reg  <= rec_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

endmodule
